### sv/brl_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer package
// Shared widths, item kinds and the setup record passed between stages.
// ----------------------------------------------------------------------------
package brl_pkg;

    // Coordinate width used inside the rasterizer.
    localparam int COORD_BITS  = 12;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int TWICE_BITS  = COORD_BITS + 2;
    localparam int DEC_BITS    = COORD_BITS + 3;

    // Port field widths.
    localparam int FIELD_BITS   = 12;
    localparam int PIX_X_BITS   = 12;
    localparam int PIX_Y_BITS   = 14;
    localparam int HEIGHT_BITS  = 13;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(1000);

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [0:0] {
        KIND_LOAD    = 1'b0,
        KIND_ADVANCE = 1'b1
    } t_kind;

    // Endpoint deltas of a load item, worked out ahead of the line setup.
    typedef struct packed {
        t_coord x_start;
        t_coord y_start;
        t_coord abs_dx;
        t_coord abs_dy;
        logic   dx_pos;
        logic   dx_neg;
        logic   dy_pos;
        logic   dy_neg;
    } t_setup;

endpackage

### sv/brl_in_if.sv
// ----------------------------------------------------------------------------
// Rasterizer command channel
// Carries load and advance items with their endpoint fields.
// ----------------------------------------------------------------------------
interface brl_in_if import brl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [FIELD_BITS-1:0] x_start;
    logic [FIELD_BITS-1:0] y_start;
    logic [FIELD_BITS-1:0] x_end;
    logic [FIELD_BITS-1:0] y_end;

    modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

### sv/brl_out_if.sv
// ----------------------------------------------------------------------------
// Rasterizer pixel channel
// Carries one emitted pixel per item, with the last-pixel flag.
// ----------------------------------------------------------------------------
interface brl_out_if import brl_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic        [PIX_X_BITS-1:0] pixel_x;
    logic signed [PIX_Y_BITS-1:0] pixel_y;
    logic                         last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

### sv/brl_cfg_if.sv
// ----------------------------------------------------------------------------
// Rasterizer configuration channel
// Carries writes of the canvas height register.
// ----------------------------------------------------------------------------
interface brl_cfg_if import brl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [HEIGHT_BITS-1:0] canvas_height;

    modport source (output valid, canvas_height, input ready);
    modport sink   (input valid, canvas_height, output ready);
endinterface

### sv/brl_setup.sv
// ----------------------------------------------------------------------------
// Rasterizer endpoint delta unit
// Forms the signed endpoint deltas and their magnitudes for a load item.
// ----------------------------------------------------------------------------
module brl_setup import brl_pkg::*; (
    input  logic [FIELD_BITS-1:0] i_x_start,
    input  logic [FIELD_BITS-1:0] i_y_start,
    input  logic [FIELD_BITS-1:0] i_x_end,
    input  logic [FIELD_BITS-1:0] i_y_end,
    output t_setup                o_setup
);

    t_coord                xa, ya, xb, yb;
    logic [DIFF_BITS-1:0]  dx, dy;
    logic [DIFF_BITS-1:0]  neg_dx, neg_dy;

    assign xa = COORD_BITS'(i_x_start);
    assign ya = COORD_BITS'(i_y_start);
    assign xb = COORD_BITS'(i_x_end);
    assign yb = COORD_BITS'(i_y_end);

    assign dx     = {1'b0, xb} - {1'b0, xa};
    assign dy     = {1'b0, yb} - {1'b0, ya};
    assign neg_dx = {1'b0, xa} - {1'b0, xb};
    assign neg_dy = {1'b0, ya} - {1'b0, yb};

    always_comb begin
        o_setup.x_start = xa;
        o_setup.y_start = ya;
        o_setup.dx_neg  = dx[DIFF_BITS-1];
        o_setup.dy_neg  = dy[DIFF_BITS-1];
        o_setup.dx_pos  = !dx[DIFF_BITS-1] && (dx != '0);
        o_setup.dy_pos  = !dy[DIFF_BITS-1] && (dy != '0);
        o_setup.abs_dx  = dx[DIFF_BITS-1] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        o_setup.abs_dy  = dy[DIFF_BITS-1] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    end

endmodule

### sv/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Sets up a line on a load item and emits one flipped-row pixel per advance on an active line.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Item
//  i_item    in   valid/ready    kind, x_start, y_start, x_end, y_end
//  o_pixel   out  valid/ready    pixel_x, pixel_y, last
//  i_cfg     in   valid/ready    canvas_height (always ready)
//
//  The block takes one item per clock when the pixel side keeps up. An
//  accepted item is first loaded into the delta stage; when the output
//  register can take a pixel, the line-state stage runs on it and, for an
//  advance, loads the output register with the pixel.
//  Reset (synchronous, active low) drops any line in progress, empties both
//  stages and sets the canvas height to 1000. When the output register holds
//  an untaken pixel, the delta stage still takes one more item; after that
//  the input side stalls until the pixel is taken.
//
module bresenham_line_rasterizer import brl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brl_in_if.sink     i_item,
    brl_cfg_if.sink    i_cfg,
    brl_out_if.source  o_pixel
);

    // ------------------------------------------------------------------
    // Stage one: register the item and the endpoint deltas of a load.
    // ------------------------------------------------------------------
    t_setup setup;

    logic   r_s1_valid;
    t_kind  r_s1_kind;
    t_setup r_s1_setup;

    // Output register, filled by the line-state stage further down.
    logic                         r_out_valid;
    logic        [PIX_X_BITS-1:0] r_out_x;
    logic signed [PIX_Y_BITS-1:0] r_out_y;
    logic                         r_out_last;

    logic   out_can;
    logic   s1_move;
    logic   in_take;

    brl_setup u_setup (
        .i_x_start (i_item.x_start),
        .i_y_start (i_item.y_start),
        .i_x_end   (i_item.x_end),
        .i_y_end   (i_item.y_end),
        .o_setup   (setup)
    );

    // The output register can take a new pixel when it is empty or being read.
    assign out_can      = !r_out_valid || o_pixel.ready;
    assign s1_move      = r_s1_valid && out_can;
    assign i_item.ready = !r_s1_valid || out_can;
    assign in_take      = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_kind  <= t_kind'(i_item.kind);
            r_s1_setup <= setup;
        end
    end

    // ------------------------------------------------------------------
    // Configuration: the canvas height is written whenever offered.
    // ------------------------------------------------------------------
    logic [HEIGHT_BITS-1:0] r_canvas_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_height <= HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            r_canvas_height <= i_cfg.canvas_height;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: line state. A load picks the major axis and seeds the
    // decision term; an advance on an active line emits the current pixel and steps once.
    // ------------------------------------------------------------------
    logic                       r_active;
    logic                       r_steep;
    t_coord                     r_major_pos;
    t_coord                     r_minor_pos;
    logic signed [DEC_BITS-1:0] r_decision;
    t_coord                     r_remaining;
    logic                       r_major_dir;
    logic                       r_minor_step;
    logic                       r_minor_neg;
    logic [TWICE_BITS-1:0]      r_twice_minor;
    logic signed [DEC_BITS-1:0] r_twice_minor_less_major;

    logic                       n_active;
    logic                       n_steep;
    t_coord                     n_major_pos;
    t_coord                     n_minor_pos;
    logic signed [DEC_BITS-1:0] n_decision;
    t_coord                     n_remaining;
    logic                       n_major_dir;
    logic                       n_minor_step;
    logic                       n_minor_neg;
    logic [TWICE_BITS-1:0]      n_twice_minor;
    logic signed [DEC_BITS-1:0] n_twice_minor_less_major;

    logic                       do_load;
    logic                       do_step;
    logic                       ld_steep;
    t_coord                     ld_amaj;
    t_coord                     ld_amin;
    t_coord                     px;
    t_coord                     ly;
    logic [PIX_Y_BITS-1:0]      row;
    logic                       is_last;

    assign do_load = s1_move && (r_s1_kind == KIND_LOAD);
    assign do_step = s1_move && (r_s1_kind == KIND_ADVANCE) && r_active;

    // Steep lines swap the axes so the major axis always moves by one.
    assign ld_steep = r_s1_setup.abs_dx < r_s1_setup.abs_dy;
    assign ld_amaj  = ld_steep ? r_s1_setup.abs_dy : r_s1_setup.abs_dx;
    assign ld_amin  = ld_steep ? r_s1_setup.abs_dx : r_s1_setup.abs_dy;

    // Current pixel in screen terms, row flipped against the canvas height.
    assign px      = r_steep ? r_minor_pos : r_major_pos;
    assign ly      = r_steep ? r_major_pos : r_minor_pos;
    assign row     = PIX_Y_BITS'(r_canvas_height) - PIX_Y_BITS'(ly);
    assign is_last = (r_remaining == COORD_BITS'(1));

    always_comb begin
        n_active                 = r_active;
        n_steep                  = r_steep;
        n_major_pos              = r_major_pos;
        n_minor_pos              = r_minor_pos;
        n_decision               = r_decision;
        n_remaining              = r_remaining;
        n_major_dir              = r_major_dir;
        n_minor_step             = r_minor_step;
        n_minor_neg              = r_minor_neg;
        n_twice_minor            = r_twice_minor;
        n_twice_minor_less_major = r_twice_minor_less_major;

        if (do_load) begin
            n_active     = 1'b1;
            n_steep      = ld_steep;
            n_major_pos  = ld_steep ? r_s1_setup.y_start : r_s1_setup.x_start;
            n_minor_pos  = ld_steep ? r_s1_setup.x_start : r_s1_setup.y_start;
            n_major_dir  = ld_steep ? !r_s1_setup.dy_pos : !r_s1_setup.dx_pos;
            n_minor_step = ld_steep ? (r_s1_setup.dx_pos || r_s1_setup.dx_neg)
                                    : (r_s1_setup.dy_pos || r_s1_setup.dy_neg);
            n_minor_neg  = ld_steep ? r_s1_setup.dx_neg : r_s1_setup.dy_neg;
            n_twice_minor = TWICE_BITS'({ld_amin, 1'b0});
            n_twice_minor_less_major = DEC_BITS'({ld_amin, 1'b0})
                                     - DEC_BITS'({ld_amaj, 1'b0});
            n_decision   = DEC_BITS'({ld_amin, 1'b0}) - DEC_BITS'(ld_amaj);
            // A line of zero length still draws its one point.
            n_remaining  = (ld_amaj == '0) ? COORD_BITS'(1) : ld_amaj;
        end else if (do_step) begin
            if (r_decision[DEC_BITS-1]) begin
                n_decision = r_decision + DEC_BITS'(r_twice_minor);
            end else begin
                n_decision = r_decision + r_twice_minor_less_major;
                if (r_minor_step) begin
                    n_minor_pos = r_minor_neg ? r_minor_pos - COORD_BITS'(1)
                                              : r_minor_pos + COORD_BITS'(1);
                end
            end
            n_major_pos = r_major_dir ? r_major_pos - COORD_BITS'(1)
                                      : r_major_pos + COORD_BITS'(1);
            n_remaining = r_remaining - COORD_BITS'(1);
            n_active    = !is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steep                  <= n_steep;
        r_major_pos              <= n_major_pos;
        r_minor_pos              <= n_minor_pos;
        r_decision               <= n_decision;
        r_remaining              <= n_remaining;
        r_major_dir              <= n_major_dir;
        r_minor_step             <= n_minor_step;
        r_minor_neg              <= n_minor_neg;
        r_twice_minor            <= n_twice_minor;
        r_twice_minor_less_major <= n_twice_minor_less_major;
    end

    // ------------------------------------------------------------------
    // Output register: holds a pixel until the sink takes it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_can) begin
            r_out_valid <= do_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_out_x    <= PIX_X_BITS'(px);
            r_out_y    <= $signed(row);
            r_out_last <= is_last;
        end
    end

    assign o_pixel.valid   = r_out_valid;
    assign o_pixel.pixel_x = r_out_x;
    assign o_pixel.pixel_y = r_out_y;
    assign o_pixel.last    = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An advance on an active line always leaves a pixel in the output.
    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_step |=> r_out_valid)
        else $error("advance on an active line produced no pixel");

    // The pixel flagged as last ends the line.
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_step && is_last) |=> !r_active)
        else $error("line still active after its last pixel");

    // A load always starts a line with at least one pixel to draw.
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_load |=> (r_active && (r_remaining != '0)))
        else $error("load did not start a line");

    // With both stages full and the sink stalled, no further item is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_pixel.ready) |-> !i_item.ready)
        else $error("item taken while both stages are blocked");

endmodule
